// ===== rtl/core/particle_euler_update_with_bounce_unit_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef PARTICLE_EULER_UPDATE_WITH_BOUNCE_UNIT_MACROS_SVH
`define PARTICLE_EULER_UPDATE_WITH_BOUNCE_UNIT_MACROS_SVH

// same-cycle implication
`define PEUB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PEUB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/peub_pkg.sv =====
package peub_pkg;

   localparam logic signed [20:0] GRAVITY_Q16 = -21'sd642908;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [50:0] Q_HALF = 51'sd32768;

   typedef enum logic [1:0] {
      CSR_MAX_BOUNCES = 2'd0,
      CSR_RESTITUTION = 2'd1,
      CSR_FRICTION    = 2'd2,
      CSR_GROUND_EN   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [7:0]  max_bounces;
      logic [16:0] restitution;
      logic [16:0] tangent_friction;
      logic        ground_enable;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] age;
      logic signed [31:0] life_span;
      logic [7:0]         bounces;
      logic signed [31:0] ground_height;
      logic [16:0]        step_time;
   } record_type;

   typedef struct packed {
      record_type         rec;
      logic signed [31:0] age_n;
      logic               live;
      logic               die;
      logic signed [38:0] pg;
      logic signed [31:0] nvy;
      logic signed [49:0] prx;
      logic signed [49:0] pry;
      logic signed [49:0] prz;
      logic signed [31:0] npx;
      logic signed [31:0] npy;
      logic signed [31:0] npz;
      logic signed [50:0] pvy;
      logic signed [49:0] pfx;
      logic signed [49:0] pfz;
      logic               hit;
      logic               over;
   } stage_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic signed [31:0] new_age;
      logic signed [31:0] new_life_span;
      logic [7:0]         new_bounces;
      logic               alive;
   } result_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q_MIN : Q_MAX;
      end
      return s[31:0];
   endfunction

   // round half up, floor by 2^16, saturate
   function automatic logic signed [31:0] rnd_sat(input logic signed [50:0] p);
      logic signed [50:0] s;
      logic [34:0]        q;
      s = p + Q_HALF;
      q = s[50:16];
      if (q[34:31] == 4'b0000 || q[34:31] == 4'b1111) begin
         return q[31:0];
      end
      return q[34] ? Q_MIN : Q_MAX;
   endfunction

endpackage

// ===== rtl/core/peub_kin.sv =====
module peub_kin (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  peub_pkg::record_type  in_rec,
   output logic                  out_valid,
   output peub_pkg::stage_type   out_stg
);
   import peub_pkg::*;

   logic [3:0] vld_ff, vld_in;
   stage_type  s1_ff, s1_in;
   stage_type  s2_ff, s2_in;
   stage_type  s3_ff, s3_in;
   stage_type  s4_ff, s4_in;
   logic signed [17:0] dt1, dt2;

   assign vld_in = {vld_ff[2:0], in_valid};
   assign dt1 = $signed({1'b0, in_rec.step_time});
   assign dt2 = $signed({1'b0, s2_ff.rec.step_time});

   // age step, gravity product
   always_comb begin
      s1_in = '0;
      s1_in.rec = in_rec;
      s1_in.age_n = sat_add(in_rec.age, $signed({15'd0, in_rec.step_time}));
      s1_in.live = (in_rec.life_span > 32'sd0);
      s1_in.pg = GRAVITY_Q16 * dt1;
   end

   // gravity into vel_y, end-of-life test
   always_comb begin
      s2_in = s1_ff;
      s2_in.nvy = sat_add(s1_ff.rec.vel_y, rnd_sat({{12{s1_ff.pg[38]}}, s1_ff.pg}));
      s2_in.die = (s1_ff.age_n >= s1_ff.rec.life_span);
   end

   // displacement products
   always_comb begin
      s3_in = s2_ff;
      s3_in.prx = s2_ff.rec.vel_x * dt2;
      s3_in.pry = s2_ff.nvy * dt2;
      s3_in.prz = s2_ff.rec.vel_z * dt2;
   end

   always_comb begin
      s4_in = s3_ff;
      s4_in.npx = sat_add(s3_ff.rec.pos_x, rnd_sat({s3_ff.prx[49], s3_ff.prx}));
      s4_in.npy = sat_add(s3_ff.rec.pos_y, rnd_sat({s3_ff.pry[49], s3_ff.pry}));
      s4_in.npz = sat_add(s3_ff.rec.pos_z, rnd_sat({s3_ff.prz[49], s3_ff.prz}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_stg   = s4_ff;

endmodule

// ===== rtl/core/peub_bnc.sv =====
module peub_bnc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  peub_pkg::stage_type   in_stg,
   input  peub_pkg::cfg_type     cfg,
   output logic                  out_valid,
   output peub_pkg::result_type  out_res
);
   import peub_pkg::*;

   logic [1:0]         vld_ff, vld_in;
   stage_type          s5_ff, s5_in;
   result_type         res_ff, res_in;
   logic signed [32:0] neg_vy;
   logic signed [17:0] rest, fric;

   assign vld_in = {vld_ff[0], in_valid};
   assign neg_vy = -$signed({in_stg.nvy[31], in_stg.nvy});
   assign rest   = $signed({1'b0, cfg.restitution});
   assign fric   = $signed({1'b0, cfg.tangent_friction});

   // ground test and bounce products side by side
   always_comb begin
      s5_in = in_stg;
      s5_in.pvy = neg_vy * rest;
      s5_in.pfx = in_stg.rec.vel_x * fric;
      s5_in.pfz = in_stg.rec.vel_z * fric;
      s5_in.hit = cfg.ground_enable && (in_stg.npy < in_stg.rec.ground_height);
      s5_in.over = (in_stg.rec.bounces >= cfg.max_bounces);
   end

   always_comb begin
      res_in.new_pos_x     = s5_ff.rec.pos_x;
      res_in.new_pos_y     = s5_ff.rec.pos_y;
      res_in.new_pos_z     = s5_ff.rec.pos_z;
      res_in.new_vel_x     = s5_ff.rec.vel_x;
      res_in.new_vel_y     = s5_ff.rec.vel_y;
      res_in.new_vel_z     = s5_ff.rec.vel_z;
      res_in.new_age       = s5_ff.rec.age;
      res_in.new_life_span = s5_ff.rec.life_span;
      res_in.new_bounces   = s5_ff.rec.bounces;
      res_in.alive         = 1'b0;
      if (s5_ff.live) begin
         res_in.new_age = s5_ff.age_n;
         if (s5_ff.die) begin
            res_in.new_life_span = '0;
         end else begin
            res_in.new_pos_x = s5_ff.npx;
            res_in.new_pos_y = s5_ff.npy;
            res_in.new_pos_z = s5_ff.npz;
            res_in.new_vel_y = s5_ff.nvy;
            if (s5_ff.hit && s5_ff.over) begin
               res_in.new_life_span = '0;
            end else begin
               res_in.alive = 1'b1;
               if (s5_ff.hit) begin
                  res_in.new_pos_y = s5_ff.rec.ground_height;
                  if (s5_ff.nvy < 32'sd0) begin
                     res_in.new_vel_y = rnd_sat(s5_ff.pvy);
                  end
                  res_in.new_vel_x   = rnd_sat({s5_ff.pfx[49], s5_ff.pfx});
                  res_in.new_vel_z   = rnd_sat({s5_ff.pfz[49], s5_ff.pfz});
                  res_in.new_bounces = s5_ff.rec.bounces + 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         s5_ff  <= s5_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_res   = res_ff;

endmodule

// ===== rtl/core/particle_euler_update_with_bounce_unit.sv =====
// Channel | Dir | Ports                        | Payload
// req     | in  | req_tvalid/tready/tdata     | particle record (320 bits)
// rsp     | out | rsp_tvalid/tready/tdata/tuser | updated record (264 bits), alive
// csr     | in  | csr_we/csr_addr/csr_wdata   | register write
//
// One record per cycle unless rsp stalls; the three multiply stages (gravity,
// displacement, bounce) are each followed by a round/saturate stage.
// Synchronous reset clears the pipeline valid bits and loads register defaults.
// A stall on rsp freezes every stage at once; req_tready drops in the same cycle.
`include "particle_euler_update_with_bounce_unit_macros.svh"

module particle_euler_update_with_bounce_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age, life_span, bounces,
   // ground_height, step_time, zero pad
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_age,
   // new_life_span, new_bounces
   output logic [263:0] rsp_tdata,
   // alive
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [16:0]  csr_wdata
);
   import peub_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   record_type in_rec;
   stage_type  mid_stg;
   result_type res;
   logic       adv, mid_valid;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign in_rec.pos_x         = req_tdata[31:0];
   assign in_rec.pos_y         = req_tdata[63:32];
   assign in_rec.pos_z         = req_tdata[95:64];
   assign in_rec.vel_x         = req_tdata[127:96];
   assign in_rec.vel_y         = req_tdata[159:128];
   assign in_rec.vel_z         = req_tdata[191:160];
   assign in_rec.age           = req_tdata[223:192];
   assign in_rec.life_span     = req_tdata[255:224];
   assign in_rec.bounces       = req_tdata[263:256];
   assign in_rec.ground_height = req_tdata[295:264];
   assign in_rec.step_time     = req_tdata[312:296];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_MAX_BOUNCES: cfg_in.max_bounces      = csr_wdata[7:0];
            CSR_RESTITUTION: cfg_in.restitution      = csr_wdata;
            CSR_FRICTION:    cfg_in.tangent_friction = csr_wdata;
            CSR_GROUND_EN:   cfg_in.ground_enable    = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_bounces      <= 8'd3;
         cfg_ff.restitution      <= 17'd32768;
         cfg_ff.tangent_friction <= 17'd45875;
         cfg_ff.ground_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   peub_kin u_kin (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_rec    (in_rec),
      .out_valid (mid_valid),
      .out_stg   (mid_stg)
   );

   peub_bnc u_bnc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mid_valid),
      .in_stg    (mid_stg),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_res   (res)
   );

   assign rsp_tdata = {res.new_bounces, res.new_life_span, res.new_age, res.new_vel_z,
                       res.new_vel_y, res.new_vel_x, res.new_pos_z, res.new_pos_y,
                       res.new_pos_x};
   assign rsp_tuser = res.alive;

   `PEUB_ASSERT_IMPL(a_dead_life, clock, reset, rsp_tvalid && !rsp_tuser, res.new_life_span <= 32'sd0)
   `PEUB_ASSERT_IMPL(a_alive_life, clock, reset, rsp_tvalid && rsp_tuser, res.new_life_span > 32'sd0)
   `PEUB_ASSERT_IMPL(a_alive_age, clock, reset, rsp_tvalid && rsp_tuser, res.new_age < res.new_life_span)
   `PEUB_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(res))

endmodule
